FILE: rtl/ifd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants of the IMU frame deframer: frame geometry,
// header and trailer code bases, controller state and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ifd_pkg;

    // frame geometry
    localparam int FRAME_BYTES  = 36;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int PAYLOAD_BYTES = 32;
    localparam int ASM_W        = $clog2(PAYLOAD_BYTES);
    localparam int MASK_W       = 13;
    localparam int SENSOR_W     = 4;

    localparam logic [POS_W-1:0] POS_HDR0    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR1    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PAY0    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_PAYN    = POS_W'(PAYLOAD_BYTES + 1);
    localparam logic [POS_W-1:0] POS_TRL0    = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] REPLAY_FIRST = POS_W'(2);

    // header and trailer code bases (sensor k: HDR0-k, HDR1+k, TRL0+k, TRL1-k)
    localparam logic [7:0] HDR0_BASE = 8'h80;
    localparam logic [7:0] HDR1_BASE = 8'hF0;
    localparam logic [7:0] TRL0_BASE = 8'hDF;
    localparam logic [7:0] TRL1_BASE = 8'hF0;

    localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(63);

    // controller states
    typedef enum logic [2:0] {
        S_IN     = 3'b001,
        S_REPLAY = 3'b010,
        S_DRAIN  = 3'b100
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             absorb_in;
        logic             absorb_rep;
        logic             rd_en;
        logic [POS_W-1:0] rd_addr;
        logic             load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_byte;
        logic is_emit;
        logic is_replay;
    } t_status;

endpackage

FILE: rtl/ifd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_datapath
// Frame window memory, header hunter, payload assembly, frame verdict and
// result register.
// ----------------------------------------------------------------------------
module ifd_datapath #(
    parameter int NUM_SENSORS = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ifd_pkg::t_cmd                 i_cmd,
    output ifd_pkg::t_status              o_status,
    input  logic                          i_cfg_we,
    input  logic [ifd_pkg::MASK_W-1:0]    i_cfg_data,
    input  logic [7:0]                    i_data_byte,
    output logic [ifd_pkg::SENSOR_W-1:0]  o_sensor_id,
    output logic [31:0]                   o_sample_index,
    output logic [31:0]                   o_quat_x,
    output logic [31:0]                   o_quat_y,
    output logic [31:0]                   o_quat_z,
    output logic [31:0]                   o_quat_w,
    output logic [31:0]                   o_accel_x,
    output logic [31:0]                   o_accel_y,
    output logic [31:0]                   o_accel_z
);

    localparam int PW = ifd_pkg::POS_W;
    localparam int SW = ifd_pkg::SENSOR_W;
    localparam int AW = ifd_pkg::ASM_W;
    localparam logic [7:0] HEAD_LOW = 8'(128 - NUM_SENSORS);

    // sensor number of a first header byte, zero when none matches
    function automatic logic [SW-1:0] head_sensor(input logic [7:0] b);
        logic [SW-1:0] k;
        k = '0;
        if (b < ifd_pkg::HDR0_BASE && b >= HEAD_LOW) begin
            k = SW'(ifd_pkg::HDR0_BASE - b);
        end
        return k;
    endfunction

    function automatic logic [SW-1:0] pair_sensor(input logic [7:0] a, input logic [7:0] b);
        logic [SW-1:0] k;
        k = head_sensor(a);
        if (k != '0 && b != ifd_pkg::HDR1_BASE + 8'(k)) begin
            k = '0;
        end
        return k;
    endfunction

    logic [7:0]    r_mem [ifd_pkg::FRAME_BYTES];
    logic [7:0]    r_rd_data;
    logic [7:0]    r_asm [ifd_pkg::PAYLOAD_BYTES];
    logic [7:0]    r_b0, r_b1, r_b34;
    logic [PW-1:0] r_fill, n_fill;
    logic          r_hunt, n_hunt;
    logic [SW-1:0] r_cand_k, n_cand_k;
    logic [ifd_pkg::MASK_W-1:0] r_mask;

    logic          absorb;
    logic [7:0]    cur_byte;
    logic [SW-1:0] cur_head;
    logic          wr_en;
    logic [PW-1:0] wr_pos;
    logic [AW-1:0] asm_off;
    logic [SW-1:0] frame_k;
    logic [15:0]   mask_ext;
    logic          enabled;
    logic          trailer_ok;
    logic          last_byte;

    function automatic logic [31:0] le32(input int base,
                                         input logic [7:0] a [ifd_pkg::PAYLOAD_BYTES]);
        return {a[base+3], a[base+2], a[base+1], a[base]};
    endfunction

    // frame verdict on the closing byte
    assign frame_k    = pair_sensor(r_b0, r_b1);
    assign mask_ext   = {{(16 - ifd_pkg::MASK_W){1'b0}}, r_mask};
    assign enabled    = (frame_k != '0) && mask_ext[4'(frame_k - SW'(1))];
    assign trailer_ok = (r_b34 == ifd_pkg::TRL0_BASE + 8'(frame_k))
                     && (i_data_byte == ifd_pkg::TRL1_BASE - 8'(frame_k));
    assign last_byte  = !r_hunt && (r_fill == ifd_pkg::POS_LAST);

    assign o_status.last_byte = last_byte;
    assign o_status.is_emit   = last_byte && enabled && trailer_ok;
    assign o_status.is_replay = last_byte && enabled && !trailer_ok;

    assign absorb   = i_cmd.absorb_in || i_cmd.absorb_rep;
    assign cur_byte = i_cmd.absorb_rep ? r_rd_data : i_data_byte;
    assign cur_head = head_sensor(cur_byte);
    assign asm_off  = AW'(wr_pos - ifd_pkg::POS_PAY0);

    // hunt for a header pair, or append to the window when in sync
    always_comb begin
        n_fill   = r_fill;
        n_hunt   = r_hunt;
        n_cand_k = r_cand_k;
        wr_en    = 1'b0;
        wr_pos   = ifd_pkg::POS_HDR0;
        if (absorb) begin
            if (r_hunt) begin
                if (r_fill == PW'(1) && cur_byte == ifd_pkg::HDR1_BASE + 8'(r_cand_k)) begin
                    wr_en  = 1'b1;
                    wr_pos = ifd_pkg::POS_HDR1;
                    n_fill = PW'(2);
                    n_hunt = 1'b0;
                end else if (cur_head != '0) begin
                    wr_en    = 1'b1;
                    wr_pos   = ifd_pkg::POS_HDR0;
                    n_fill   = PW'(1);
                    n_cand_k = cur_head;
                end else begin
                    n_fill = '0;
                end
            end else begin
                wr_en  = 1'b1;
                wr_pos = r_fill;
                n_fill = r_fill + PW'(1);
                if (r_fill == ifd_pkg::POS_LAST) begin
                    n_fill = '0;
                    if (!(enabled && trailer_ok)) begin
                        n_hunt = 1'b1;
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_hunt <= 1'b1;
            r_mask <= ifd_pkg::MASK_RESET;
        end else begin
            r_fill <= n_fill;
            r_hunt <= n_hunt;
            if (i_cfg_we) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    // window memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_pos] <= cur_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    // header, trailer and payload byte capture
    always_ff @(posedge i_clk) begin
        r_cand_k <= n_cand_k;
        if (wr_en) begin
            if (wr_pos == ifd_pkg::POS_HDR0) begin
                r_b0 <= cur_byte;
            end
            if (wr_pos == ifd_pkg::POS_HDR1) begin
                r_b1 <= cur_byte;
            end
            if (wr_pos == ifd_pkg::POS_TRL0) begin
                r_b34 <= cur_byte;
            end
            if (wr_pos >= ifd_pkg::POS_PAY0 && wr_pos <= ifd_pkg::POS_PAYN) begin
                r_asm[asm_off] <= cur_byte;
            end
        end
    end

    // result register: permute and flip the quaternion on load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_sensor_id    <= frame_k;
            o_sample_index <= le32(0, r_asm);
            o_quat_w       <= le32(4, r_asm) ^ 32'h8000_0000;
            o_quat_z       <= le32(8, r_asm);
            o_quat_y       <= le32(12, r_asm) ^ 32'h8000_0000;
            o_quat_x       <= le32(16, r_asm);
            o_accel_x      <= le32(20, r_asm);
            o_accel_y      <= le32(24, r_asm);
            o_accel_z      <= le32(28, r_asm);
        end
    end

endmodule

FILE: rtl/ifd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_ctrl
// Controller: input and output handshakes and the replay sequence that
// re-scans the window after a bad trailer.
// ----------------------------------------------------------------------------
module ifd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  ifd_pkg::t_status i_status,
    output ifd_pkg::t_cmd    o_cmd
);

    localparam int PW = ifd_pkg::POS_W;

    ifd_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_rd_addr, n_rd_addr;
    logic            r_rd_pend;
    logic            r_out_valid, n_out_valid;
    logic            in_fire;

    // hold input off while replaying, or when a result would find the output full
    assign o_ready = (r_state == ifd_pkg::S_IN)
                  && (!i_status.last_byte || !r_out_valid || i_ready);
    assign in_fire = i_valid && o_ready;
    assign o_valid = r_out_valid;

    always_comb begin
        n_state          = r_state;
        n_rd_addr        = r_rd_addr;
        o_cmd.absorb_in  = in_fire;
        o_cmd.absorb_rep = r_rd_pend;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_addr    = r_rd_addr;
        o_cmd.load_out   = in_fire && i_status.is_emit;
        case (r_state)
            ifd_pkg::S_IN: begin
                if (in_fire && i_status.is_replay) begin
                    n_state   = ifd_pkg::S_REPLAY;
                    n_rd_addr = ifd_pkg::REPLAY_FIRST;
                end
            end
            ifd_pkg::S_REPLAY: begin
                o_cmd.rd_en = 1'b1;
                n_rd_addr   = r_rd_addr + PW'(1);
                if (r_rd_addr == ifd_pkg::POS_LAST) begin
                    n_state = ifd_pkg::S_DRAIN;
                end
            end
            ifd_pkg::S_DRAIN: begin
                n_state = ifd_pkg::S_IN;
            end
            default: begin
                n_state = ifd_pkg::S_IN;
            end
        endcase
    end

    // result beat held until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ifd_pkg::S_IN;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= o_cmd.rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
    end

endmodule

FILE: rtl/imu_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_deframer
// Finds 36-byte sensor frames in a byte stream by header pair, checks the
// sensor enable mask and trailer, and emits index, rotated quaternion and
// acceleration words.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_data_byte
//   result    out        o_valid / i_ready   o_sensor_id .. o_accel_z
//   config    in         i_cfg_we            i_cfg_data (enable mask)
//
// One input byte is taken per cycle while hunting or filling the window, when not held.
// A bad trailer starts a re-scan of 34 window bytes through the single
// memory read port: input is held through the replay and drain states.
// A closing byte is held while the result register is still full and not
// being taken. Reset is synchronous and leaves the block hunting with the
// mask at 63; no clearing pass is needed.
// ----------------------------------------------------------------------------
module imu_frame_deframer #(
    parameter int NUM_SENSORS = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ifd_pkg::MASK_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ifd_pkg::SENSOR_W-1:0]  o_sensor_id,
    output logic [31:0]                   o_sample_index,
    output logic [31:0]                   o_quat_x,
    output logic [31:0]                   o_quat_y,
    output logic [31:0]                   o_quat_z,
    output logic [31:0]                   o_quat_w,
    output logic [31:0]                   o_accel_x,
    output logic [31:0]                   o_accel_y,
    output logic [31:0]                   o_accel_z
);

    ifd_pkg::t_cmd    cmd;
    ifd_pkg::t_status status;

    // sequence handshakes and replay
    ifd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // window, hunter and result register
    ifd_datapath #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_data_byte    (i_data_byte),
        .o_sensor_id    (o_sensor_id),
        .o_sample_index (o_sample_index),
        .o_quat_x       (o_quat_x),
        .o_quat_y       (o_quat_y),
        .o_quat_z       (o_quat_z),
        .o_quat_w       (o_quat_w),
        .o_accel_x      (o_accel_x),
        .o_accel_y      (o_accel_y),
        .o_accel_z      (o_accel_z)
    );

endmodule
